[sv/vrpt_pkg.sv]
// shared types, constants and helper functions of the reference point transform
package vrpt_pkg;

  localparam int NUM_POINTS_DEF   = 4;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int POINT_W          = 2;
  localparam int DATA_W           = 32;
  localparam int CFG_IDX_W        = 3;
  localparam int FLAGS_W          = 3;
  localparam int FLOOR_W          = 31;
  localparam int MASK_W           = 4;
  localparam int DIV_BITS         = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 3'd5;

  localparam logic [MASK_W-1:0]  MASK_RST  = 4'hF;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 31'd66;

  localparam int PRES_YAW  = 0;
  localparam int PRES_CURV = 1;
  localparam int PRES_VEL  = 2;
  localparam logic [FLAGS_W-1:0] PRES_ALL = 3'b111;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

  typedef struct packed {
    logic                    bad;
    logic                    xform;
    logic                    need_vk;
    logic                    sat;
    logic [POINT_W-1:0]      tgt;
    logic [FLAGS_W-1:0]      flags;
    logic [15:0]             heading;
    logic signed [32:0]      delta;
    logic signed [31:0]      px;
    logic signed [31:0]      py;
    logic signed [31:0]      v;
    logic signed [31:0]      lat;
    logic signed [31:0]      acc;
    logic signed [31:0]      w;
    logic signed [31:0]      k;
  } item_t;

  typedef struct packed {
    logic                en;
    logic                neg;
    logic [31:0]         den;
    logic [31:0]         rem;
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cord_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] a;
    case (i)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10680862;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      24:      a = 32'd41;
      25:      a = 32'd20;
      26:      a = 32'd10;
      27:      a = 32'd5;
      28:      a = 32'd3;
      29:      a = 32'd1;
      30:      a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t s;
    if (v > 64'sd2147483647) begin
      s.clip = 1'b1;
      s.val  = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      s.clip = 1'b1;
      s.val  = 32'sh80000000;
    end else begin
      s.clip = 1'b0;
      s.val  = v[31:0];
    end
    return s;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

endpackage

[sv/vehicle_reference_point_transform.sv]
// One item enters per cycle while no valid output is stalled: the item runs through
// multiply stages, a 48-cell restoring divider for the curvature and a CORDIC_STEPS-cell
// rotation chain for cos and sin of the heading, all pipelined. A stall on a valid
// output holds the whole pipeline; the output register keeps its result. Offsets and
// support mask are read when an item enters, the speed floor at the divider setup stage,
// so the user must write all of them only while the pipeline is empty (not enforced).
module vehicle_reference_point_transform #(
  parameter int NUM_POINTS   = vrpt_pkg::NUM_POINTS_DEF,
  parameter int CORDIC_STEPS = vrpt_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vrpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vrpt_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [vrpt_pkg::POINT_W-1:0]        in_source_point,
  input  logic [vrpt_pkg::POINT_W-1:0]        in_target_point,
  input  logic signed [31:0]                  in_pos_x,
  input  logic signed [31:0]                  in_pos_y,
  input  logic [15:0]                         in_heading,
  input  logic signed [31:0]                  in_lin_vel,
  input  logic signed [31:0]                  in_lat_vel,
  input  logic signed [31:0]                  in_lin_acc,
  input  logic signed [31:0]                  in_yaw_rate,
  input  logic signed [31:0]                  in_curvature,
  input  logic [vrpt_pkg::FLAGS_W-1:0]        in_present_flags,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_status,
  output logic [vrpt_pkg::POINT_W-1:0]        out_point,
  output logic signed [31:0]                  out_x,
  output logic signed [31:0]                  out_y,
  output logic signed [31:0]                  out_lin_vel,
  output logic signed [31:0]                  out_lat_vel,
  output logic signed [31:0]                  out_lin_acc,
  output logic signed [31:0]                  out_yaw_rate,
  output logic signed [31:0]                  out_curvature,
  output logic [vrpt_pkg::FLAGS_W-1:0]        out_flags,
  output logic                                out_saturated
);

  localparam int NDIV = vrpt_pkg::DIV_BITS;

  logic signed [31:0]               off_a_r, off_b_r, off_c_r, off_d_r;
  logic [vrpt_pkg::MASK_W-1:0]      mask_r;
  logic [vrpt_pkg::FLOOR_W-1:0]     floor_r;
  logic                             en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_a_r <= '0;
      off_b_r <= '0;
      off_c_r <= '0;
      off_d_r <= '0;
      mask_r  <= vrpt_pkg::MASK_RST;
      floor_r <= vrpt_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vrpt_pkg::CFG_OFFSET_A: off_a_r <= cfg_data;
        vrpt_pkg::CFG_OFFSET_B: off_b_r <= cfg_data;
        vrpt_pkg::CFG_OFFSET_C: off_c_r <= cfg_data;
        vrpt_pkg::CFG_OFFSET_D: off_d_r <= cfg_data;
        vrpt_pkg::CFG_MASK:     mask_r  <= cfg_data[vrpt_pkg::MASK_W-1:0];
        vrpt_pkg::CFG_FLOOR:    floor_r <= cfg_data[vrpt_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [31:0] pick_off(input logic [1:0] p,
      input logic signed [31:0] a, input logic signed [31:0] b,
      input logic signed [31:0] c, input logic signed [31:0] d);
    logic signed [31:0] o;
    case (p)
      2'd0:    o = a;
      2'd1:    o = b;
      2'd2:    o = c;
      default: o = d;
    endcase
    return o;
  endfunction

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: entry, support check, offset difference
  vrpt_pkg::item_t    s1_nxt, s1_r;
  logic               s1_v_r;
  logic signed [31:0] off_s, off_t;
  logic               src_ok, tgt_ok;

  always_comb begin
    off_s  = pick_off(in_source_point, off_a_r, off_b_r, off_c_r, off_d_r);
    off_t  = pick_off(in_target_point, off_a_r, off_b_r, off_c_r, off_d_r);
    src_ok = (int'(in_source_point) < NUM_POINTS) && mask_r[in_source_point];
    tgt_ok = (int'(in_target_point) < NUM_POINTS) && mask_r[in_target_point];
    s1_nxt.bad     = !(src_ok && tgt_ok);
    s1_nxt.tgt     = in_target_point;
    s1_nxt.heading = in_heading;
    s1_nxt.sat     = 1'b0;
    s1_nxt.delta   = {off_t[31], off_t} - {off_s[31], off_s};
    s1_nxt.xform   = !s1_nxt.bad && (in_source_point != in_target_point) &&
                     (s1_nxt.delta != '0);
    s1_nxt.need_vk = !in_present_flags[vrpt_pkg::PRES_YAW] &&
                     in_present_flags[vrpt_pkg::PRES_CURV] &&
                     in_present_flags[vrpt_pkg::PRES_VEL];
    s1_nxt.px  = in_pos_x;
    s1_nxt.py  = in_pos_y;
    s1_nxt.lat = in_lat_vel;
    s1_nxt.acc = in_lin_acc;
    s1_nxt.v   = in_present_flags[vrpt_pkg::PRES_VEL]  ? in_lin_vel   : '0;
    s1_nxt.w   = in_present_flags[vrpt_pkg::PRES_YAW]  ? in_yaw_rate  : '0;
    s1_nxt.k   = in_present_flags[vrpt_pkg::PRES_CURV] ? in_curvature : '0;
    s1_nxt.flags = s1_nxt.xform ? vrpt_pkg::PRES_ALL : in_present_flags;
    if (s1_nxt.bad) begin
      s1_nxt.px    = '0;
      s1_nxt.py    = '0;
      s1_nxt.v     = '0;
      s1_nxt.lat   = '0;
      s1_nxt.acc   = '0;
      s1_nxt.w     = '0;
      s1_nxt.k     = '0;
      s1_nxt.flags = '0;
    end
  end

  // stage 2: speed times curvature
  vrpt_pkg::item_t s2_r;
  logic            s2_v_r;
  logic [63:0]     s2_p_r;
  logic            s2_neg_r;

  // stage 3: yaw rate from speed and curvature
  vrpt_pkg::item_t s3_nxt, s3_r;
  logic            s3_v_r;
  logic [63:0]     s3_sum;
  logic [63:0]     s3_mag;
  vrpt_pkg::sat_t  s3_sat;

  always_comb begin
    s3_sum = s2_p_r + 64'd32768;
    s3_mag = {16'd0, s3_sum[63:16]};
    s3_sat = vrpt_pkg::sat32(s2_neg_r ? -$signed(s3_mag) : $signed(s3_mag));
    s3_nxt = s2_r;
    if (s2_r.xform && s2_r.need_vk) begin
      s3_nxt.w   = s3_sat.val;
      s3_nxt.sat = s2_r.sat | s3_sat.clip;
    end
  end

  // stage 4: yaw rate times offset, yaw rate squared
  vrpt_pkg::item_t s4_r;
  logic            s4_v_r;
  logic [64:0]     s4_pwd_r;
  logic [63:0]     s4_pww_r;
  logic            s4_neg_r;

  // stage 5: lateral velocity, rounded yaw rate squared
  vrpt_pkg::item_t    s5_nxt, s5_r;
  logic               s5_v_r;
  logic [46:0]        s5_w2_r;
  logic [65:0]        s5_lsum;
  logic [63:0]        s5_lmag;
  logic [63:0]        s5_wsum;
  vrpt_pkg::sat_t     s5_sat;

  always_comb begin
    s5_lsum = {1'b0, s4_pwd_r} + 66'd32768;
    s5_lmag = {14'd0, s5_lsum[65:16]};
    s5_wsum = s4_pww_r + 64'd32768;
    s5_sat  = vrpt_pkg::sat32(64'(s4_r.lat) +
                              (s4_neg_r ? -$signed(s5_lmag) : $signed(s5_lmag)));
    s5_nxt  = s4_r;
    if (s4_r.xform) begin
      s5_nxt.lat = s5_sat.val;
      s5_nxt.sat = s4_r.sat | s5_sat.clip;
    end
  end

  // stage 6: partial products of squared yaw rate times offset
  vrpt_pkg::item_t s6_r;
  logic            s6_v_r;
  logic [64:0]     s6_pl_r;
  logic [47:0]     s6_ph_r;

  // stage 7: acceleration, divider setup
  vrpt_pkg::item_t s7_nxt, s7_r;
  logic            s7_v_r;
  vrpt_pkg::div_t  s7_div_nxt, s7_div_r;
  logic [80:0]     s7_prod;
  logic [80:0]     s7_sum;
  logic [64:0]     s7_rnd;
  logic [63:0]     s7_mag;
  vrpt_pkg::sat_t  s7_sat;

  always_comb begin
    s7_prod = {1'b0, s6_ph_r, 32'd0} + {16'd0, s6_pl_r};
    s7_sum  = s7_prod + 81'd32768;
    s7_rnd  = s7_sum[80:16];
    s7_mag  = (s7_rnd > 65'h200000000) ? 64'h200000000 : s7_rnd[63:0];
    s7_sat  = vrpt_pkg::sat32(64'(s6_r.acc) +
                              (s6_r.delta[32] ? $signed(s7_mag) : -$signed(s7_mag)));
    s7_nxt  = s6_r;
    if (s6_r.xform) begin
      s7_nxt.acc = s7_sat.val;
      s7_nxt.sat = s6_r.sat | s7_sat.clip;
    end
    s7_div_nxt.en  = s6_r.xform &&
                     (vrpt_pkg::mag32(s6_r.v) > {1'b0, floor_r});
    s7_div_nxt.neg = s6_r.w[31] ^ s6_r.v[31];
    s7_div_nxt.den = vrpt_pkg::mag32(s6_r.v);
    s7_div_nxt.rem = '0;
    s7_div_nxt.num = {vrpt_pkg::mag32(s6_r.w), 16'd0};
    s7_div_nxt.quo = '0;
  end

  // divider chain
  logic            dv_v  [0:NDIV];
  vrpt_pkg::item_t dv_it [0:NDIV];
  vrpt_pkg::div_t  dv_d  [0:NDIV];

  assign dv_v[0]  = s7_v_r;
  assign dv_it[0] = s7_r;
  assign dv_d[0]  = s7_div_r;

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    vrpt_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (dv_v[g]),
      .item_i (dv_it[g]),
      .div_i  (dv_d[g]),
      .vld_o  (dv_v[g+1]),
      .item_o (dv_it[g+1]),
      .div_o  (dv_d[g+1])
    );
  end

  // stage 8: curvature, cordic setup
  vrpt_pkg::item_t s8_nxt, s8_r;
  logic            s8_v_r;
  vrpt_pkg::cord_t s8_cd_nxt, s8_cd_r;
  vrpt_pkg::sat_t  s8_sat;
  logic [63:0]     s8_q;
  logic [15:0]     s8_hsum;
  logic [15:0]     s8_rr;

  always_comb begin
    s8_q   = {16'd0, dv_d[NDIV].quo};
    s8_sat = vrpt_pkg::sat32(dv_d[NDIV].neg ? -$signed(s8_q) : $signed(s8_q));
    s8_nxt = dv_it[NDIV];
    if (dv_d[NDIV].en) begin
      s8_nxt.k   = s8_sat.val;
      s8_nxt.sat = dv_it[NDIV].sat | s8_sat.clip;
    end
    s8_hsum        = dv_it[NDIV].heading + 16'd8192;
    s8_cd_nxt.quad = s8_hsum[15:14];
    s8_rr          = dv_it[NDIV].heading - {s8_hsum[15:14], 14'd0};
    s8_cd_nxt.x    = vrpt_pkg::CORDIC_X0;
    s8_cd_nxt.y    = '0;
    s8_cd_nxt.z    = {s8_rr, 16'd0};
  end

  // cordic chain
  logic            cd_v  [0:CORDIC_STEPS];
  vrpt_pkg::item_t cd_it [0:CORDIC_STEPS];
  vrpt_pkg::cord_t cd_d  [0:CORDIC_STEPS];

  assign cd_v[0]  = s8_v_r;
  assign cd_it[0] = s8_r;
  assign cd_d[0]  = s8_cd_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cord
    vrpt_cordic_cell #(.STEP(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (cd_v[g]),
      .item_i (cd_it[g]),
      .cd_i   (cd_d[g]),
      .vld_o  (cd_v[g+1]),
      .item_o (cd_it[g+1]),
      .cd_o   (cd_d[g+1])
    );
  end

  // stage 9: quadrant fold back
  vrpt_pkg::item_t    s9_r;
  logic               s9_v_r;
  logic signed [31:0] s9_c_nxt, s9_s_nxt, s9_c_r, s9_s_r;

  always_comb begin
    case (cd_d[CORDIC_STEPS].quad)
      vrpt_pkg::QUAD_0: begin
        s9_c_nxt = cd_d[CORDIC_STEPS].x;
        s9_s_nxt = cd_d[CORDIC_STEPS].y;
      end
      vrpt_pkg::QUAD_1: begin
        s9_c_nxt = -cd_d[CORDIC_STEPS].y;
        s9_s_nxt = cd_d[CORDIC_STEPS].x;
      end
      vrpt_pkg::QUAD_2: begin
        s9_c_nxt = -cd_d[CORDIC_STEPS].x;
        s9_s_nxt = -cd_d[CORDIC_STEPS].y;
      end
      default: begin
        s9_c_nxt = cd_d[CORDIC_STEPS].y;
        s9_s_nxt = -cd_d[CORDIC_STEPS].x;
      end
    endcase
  end

  // stage 10: position products
  vrpt_pkg::item_t s10_r;
  logic            s10_v_r;
  logic [64:0]     s10_px_r, s10_py_r;
  logic            s10_nx_r, s10_ny_r;

  // stage 11: output register
  logic [64:0]    o_xsum, o_ysum;
  logic [63:0]    o_xmag, o_ymag;
  vrpt_pkg::sat_t o_xsat, o_ysat;
  logic           o_xform;

  always_comb begin
    o_xsum  = s10_px_r + 65'd536870912;
    o_ysum  = s10_py_r + 65'd536870912;
    o_xmag  = {29'd0, o_xsum[64:30]};
    o_ymag  = {29'd0, o_ysum[64:30]};
    o_xsat  = vrpt_pkg::sat32(64'(s10_r.px) +
                              (s10_nx_r ? -$signed(o_xmag) : $signed(o_xmag)));
    o_ysat  = vrpt_pkg::sat32(64'(s10_r.py) +
                              (s10_ny_r ? -$signed(o_ymag) : $signed(o_ymag)));
    o_xform = s10_r.xform;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      s5_v_r    <= 1'b0;
      s6_v_r    <= 1'b0;
      s7_v_r    <= 1'b0;
      s8_v_r    <= 1'b0;
      s9_v_r    <= 1'b0;
      s10_v_r   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      s6_v_r    <= s5_v_r;
      s7_v_r    <= s6_v_r;
      s8_v_r    <= dv_v[NDIV];
      s9_v_r    <= cd_v[CORDIC_STEPS];
      s10_v_r   <= s9_v_r;
      out_valid <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= s1_nxt;
      s2_r     <= s1_r;
      s2_p_r   <= 64'(vrpt_pkg::mag32(s1_r.v)) * 64'(vrpt_pkg::mag32(s1_r.k));
      s2_neg_r <= s1_r.v[31] ^ s1_r.k[31];
      s3_r     <= s3_nxt;
      s4_r     <= s3_r;
      s4_pwd_r <= 65'(vrpt_pkg::mag32(s3_r.w)) * 65'(vrpt_pkg::mag33(s3_r.delta));
      s4_pww_r <= 64'(vrpt_pkg::mag32(s3_r.w)) * 64'(vrpt_pkg::mag32(s3_r.w));
      s4_neg_r <= s3_r.w[31] ^ s3_r.delta[32];
      s5_r     <= s5_nxt;
      s5_w2_r  <= s5_wsum[62:16];
      s6_r     <= s5_r;
      s6_pl_r  <= 65'(s5_w2_r[31:0]) * 65'(vrpt_pkg::mag33(s5_r.delta));
      s6_ph_r  <= 48'(s5_w2_r[46:32]) * 48'(vrpt_pkg::mag33(s5_r.delta));
      s7_r     <= s7_nxt;
      s7_div_r <= s7_div_nxt;
      s8_r     <= s8_nxt;
      s8_cd_r  <= s8_cd_nxt;
      s9_r     <= cd_it[CORDIC_STEPS];
      s9_c_r   <= s9_c_nxt;
      s9_s_r   <= s9_s_nxt;
      s10_r    <= s9_r;
      s10_px_r <= 65'(vrpt_pkg::mag32(s9_c_r)) * 65'(vrpt_pkg::mag33(s9_r.delta));
      s10_py_r <= 65'(vrpt_pkg::mag32(s9_s_r)) * 65'(vrpt_pkg::mag33(s9_r.delta));
      s10_nx_r <= s9_c_r[31] ^ s9_r.delta[32];
      s10_ny_r <= s9_s_r[31] ^ s9_r.delta[32];
      out_status    <= s10_r.bad;
      out_point     <= s10_r.tgt;
      out_x         <= o_xform ? o_xsat.val : s10_r.px;
      out_y         <= o_xform ? o_ysat.val : s10_r.py;
      out_lin_vel   <= s10_r.v;
      out_lat_vel   <= s10_r.lat;
      out_lin_acc   <= s10_r.acc;
      out_yaw_rate  <= s10_r.w;
      out_curvature <= s10_r.k;
      out_flags     <= s10_r.flags;
      out_saturated <= o_xform ? (s10_r.sat | o_xsat.clip | o_ysat.clip) : s10_r.sat;
    end
  end

  // unsupported points give an all-zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_flags == '0 && !out_saturated &&
      out_yaw_rate == '0 && out_curvature == '0)
    else $error("unsupported point result not cleared");

  // pass-through items never clip
  a_pass_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status && out_flags != vrpt_pkg::PRES_ALL |-> !out_saturated)
    else $error("pass-through item flagged saturated");

  // a stalled pipeline keeps its entry stage
  a_hold_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_v_r == $past(s1_v_r))
    else $error("entry stage moved under stall");

endmodule

[sv/vrpt_div_cell.sv]
// one restoring division cell: one quotient bit per cell, item carried alongside
module vrpt_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  vrpt_pkg::item_t   item_i,
  input  vrpt_pkg::div_t    div_i,
  output logic              vld_o,
  output vrpt_pkg::item_t   item_o,
  output vrpt_pkg::div_t    div_o
);

  logic [32:0]    trial;
  logic [32:0]    diff;
  logic           ge;
  vrpt_pkg::div_t div_nxt;

  always_comb begin
    trial   = {div_i.rem, div_i.num[vrpt_pkg::DIV_BITS-1]};
    diff    = trial - {1'b0, div_i.den};
    ge      = trial >= {1'b0, div_i.den};
    div_nxt = div_i;
    div_nxt.rem = ge ? diff[31:0] : trial[31:0];
    div_nxt.num = {div_i.num[vrpt_pkg::DIV_BITS-2:0], 1'b0};
    div_nxt.quo = {div_i.quo[vrpt_pkg::DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_o <= item_i;
      div_o  <= div_nxt;
    end
  end

endmodule

[sv/vrpt_cordic_cell.sv]
// one cordic rotation cell, item carried alongside
module vrpt_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  vrpt_pkg::item_t   item_i,
  input  vrpt_pkg::cord_t   cd_i,
  output logic              vld_o,
  output vrpt_pkg::item_t   item_o,
  output vrpt_pkg::cord_t   cd_o
);

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] ang;
  vrpt_pkg::cord_t    cd_nxt;

  always_comb begin
    dx     = cd_i.y >>> STEP;
    dy     = cd_i.x >>> STEP;
    ang    = vrpt_pkg::atan_at(STEP);
    cd_nxt = cd_i;
    if (!cd_i.z[31]) begin
      cd_nxt.x = cd_i.x - dx;
      cd_nxt.y = cd_i.y + dy;
      cd_nxt.z = cd_i.z - ang;
    end else begin
      cd_nxt.x = cd_i.x + dx;
      cd_nxt.y = cd_i.y - dy;
      cd_nxt.z = cd_i.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_o <= item_i;
      cd_o   <= cd_nxt;
    end
  end

endmodule
